/* hw/rtl/edt_pkg.sv */
package edt_pkg;

    // Fixed field widths of the stream payload
    localparam int CNT_W   = 12;
    localparam int MEAN_W  = 12;
    localparam int OCT_W   = 4;
    localparam int PER_W   = 8;
    localparam int HALF_W  = 7;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;

    // Default sizes and register reset
    localparam int DEF_WINDOW_LEN   = 20;
    localparam int DEF_TIMEOUT_HIGH = 11;
    localparam logic [OCT_W-1:0] OFFSET_RESET = 4'd2;

    // Ticks per timeout step
    localparam int TICKS_PER_STEP = 256;

endpackage

/* hw/rtl/echo_distance_to_tone.sv */
// Echo timer with moving-average tone mapping. Each input transfer is one timer
// tick carrying the sampled echo level in bit 0 of i_s_tdata; a rising edge clears
// and starts the tick counter, a falling edge stops it and, if the count is below
// TIMEOUT_HIGH*256, pushes it into a row of WINDOW_LEN shift cells and emits one
// result: window mean, octave code, tone period and half period. The block takes
// one tick per clock unless stalled. A result leaves through a five-stage
// pipeline (sum register, reciprocal multiply for the mean, octave split,
// reciprocal multiply for the period fraction, output register); input stalls
// only when that pipeline is full and the output is not taken. The octave offset
// register (reset 2) is written through the cfg channel; the user must write it only
// while the block is idle, unenforced by the block. No clearing pass is needed after reset.
module echo_distance_to_tone import edt_pkg::*; #(
    parameter int WINDOW_LEN   = DEF_WINDOW_LEN,
    parameter int TIMEOUT_HIGH = DEF_TIMEOUT_HIGH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [0] echo_level, [7:1] zero
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [11:0] mean_distance, [15:12] octave_code,
                                              // [23:16] tone_period, [30:24] tone_half_period,
                                              // [31] zero
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [OCT_W-1:0]     i_cfg_data   // octave_offset
);

    localparam int SUM_W = CNT_W + $clog2(WINDOW_LEN);
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(TIMEOUT_HIGH * TICKS_PER_STEP);

    logic               r_prev, n_prev;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_counting, n_counting;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [OCT_W-1:0]   r_offset;

    logic               w_accept, w_level, w_rise, w_fall, w_push;
    logic [CNT_W-1:0]   w_tap [0:WINDOW_LEN];

    logic [MEAN_W-1:0]  w_mean;
    logic [OCT_W-1:0]   w_oct;
    logic [PER_W-1:0]   w_per;
    logic [HALF_W-1:0]  w_half;

    // Config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_offset <= i_cfg_data;
        end
    end

    // Edge detect on each accepted tick
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_level  = i_s_tdata[0];
    assign w_rise   = w_level && !r_prev;
    assign w_fall   = !w_level && r_prev;
    assign w_push   = w_accept && w_fall && (r_cnt < LIMIT);

    // Counter control and running window sum
    always_comb begin
        n_prev     = r_prev;
        n_cnt      = r_cnt;
        n_counting = r_counting;
        n_sum      = r_sum;
        if (w_accept) begin
            n_prev = w_level;
            if (w_rise) begin
                n_cnt      = '0;
                n_counting = 1'b1;
            end else if (w_fall) begin
                n_counting = 1'b0;
            end else if (r_counting) begin
                n_cnt      = r_cnt + 1'b1;
                n_counting = (n_cnt != LIMIT);
            end
        end
        if (w_push) begin
            n_sum = r_sum - SUM_W'(w_tap[WINDOW_LEN]) + SUM_W'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= 1'b0;
            r_cnt      <= '0;
            r_counting <= 1'b1;
            r_sum      <= '0;
        end else begin
            r_prev     <= n_prev;
            r_cnt      <= n_cnt;
            r_counting <= n_counting;
            r_sum      <= n_sum;
        end
    end

    // Window row: newest width enters cell 0, oldest drops out of the last cell
    assign w_tap[0] = r_cnt;

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        edt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_push),
            .i_sample (w_tap[g]),
            .o_sample (w_tap[g+1])
        );
    end

    // Mean and tone mapping pipeline
    edt_tone #(
        .WINDOW_LEN   (WINDOW_LEN),
        .TIMEOUT_HIGH (TIMEOUT_HIGH),
        .SUM_W        (SUM_W)
    ) u_tone (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_push),
        .o_ready  (o_s_tready),
        .i_sum    (n_sum),
        .i_offset (r_offset),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_mean   (w_mean),
        .o_oct    (w_oct),
        .o_per    (w_per),
        .o_half   (w_half)
    );

    assign o_m_tdata = {1'b0, w_half, w_per, w_oct, w_mean};

endmodule

/* hw/rtl/edt_cell.sv */
module edt_cell import edt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [CNT_W-1:0] i_sample,
    output logic [CNT_W-1:0] o_sample
);

    logic [CNT_W-1:0] r_sample;
    logic [CNT_W-1:0] n_sample;

    // Take the neighbor's sample on a push, hold otherwise
    always_comb begin
        n_sample = r_sample;
        if (i_shift) begin
            n_sample = i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

/* hw/rtl/edt_tone.sv */
module edt_tone import edt_pkg::*; #(
    parameter int WINDOW_LEN   = DEF_WINDOW_LEN,
    parameter int TIMEOUT_HIGH = DEF_TIMEOUT_HIGH,
    parameter int SUM_W        = CNT_W + $clog2(WINDOW_LEN)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [OCT_W-1:0]  i_offset,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MEAN_W-1:0] o_mean,
    output logic [OCT_W-1:0]  o_oct,
    output logic [PER_W-1:0]  o_per,
    output logic [HALF_W-1:0] o_half
);

    // Mean = sum / WINDOW_LEN by exact reciprocal multiply
    localparam int L1      = $clog2(WINDOW_LEN);
    localparam int SH1     = SUM_W + L1;
    localparam int M1_W    = SUM_W + 1;
    localparam int M1_INT  = ((1 << SH1) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [M1_W-1:0] M1 = M1_W'(M1_INT);
    localparam int PROD1_W = SUM_W + M1_W;

    // Octave split: d = K * 256, K = TIMEOUT_HIGH / 2
    localparam int K       = TIMEOUT_HIGH / 2;
    localparam int HI_W    = $clog2(K + 1);
    localparam int REM_W   = HI_W + 8;

    // Period fraction = rem / (2 * K) by exact reciprocal multiply
    localparam int D2      = 2 * K;
    localparam int L2      = $clog2(D2);
    localparam int SH2     = REM_W + L2;
    localparam int M2_W    = REM_W + 1;
    localparam int M2_INT  = ((1 << SH2) + D2 - 1) / D2;
    localparam logic [M2_W-1:0] M2 = M2_W'(M2_INT);
    localparam int PROD2_W = REM_W + M2_W;
    localparam int FRAC_W  = PER_W - 1;

    // Quotient of the top mean nibble by K, as parallel compares
    function automatic logic [OCT_W-1:0] f_oct_quot(input logic [OCT_W-1:0] hi);
        logic [OCT_W-1:0] q;
        q = '0;
        for (int j = 1; j < 16; j++) begin
            if (int'(hi) >= j * K) begin
                q = OCT_W'(j);
            end
        end
        return q;
    endfunction

    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    logic                w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic [SUM_W-1:0]    r_sum1;
    logic [PROD1_W-1:0]  r_prod1;
    logic [MEAN_W-1:0]   r_mean3, r_mean4, r_mean5;
    logic [OCT_W-1:0]    r_oct3, r_oct4, r_oct5;
    logic [REM_W-1:0]    r_rem3;
    logic [PROD2_W-1:0]  r_prod2;
    logic [PER_W-1:0]    r_per5;
    logic [HALF_W-1:0]   r_half5;

    logic [MEAN_W-1:0]   w_mean;
    logic [OCT_W-1:0]    w_hi;
    logic [OCT_W-1:0]    w_quot;
    logic [HI_W-1:0]     w_remhi;
    logic [FRAC_W-1:0]   w_frac;

    // Advance a stage when it is empty or its successor advances
    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign o_ready = !r_v1 || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (w_rdy2)  r_v2 <= r_v1;
            if (w_rdy3)  r_v3 <= r_v2;
            if (w_rdy4)  r_v4 <= r_v3;
            if (w_rdy5)  r_v5 <= r_v4;
        end
    end

    // Split the mean into octave index and remainder
    assign w_mean  = r_prod1[SH1 +: MEAN_W];
    assign w_hi    = w_mean[MEAN_W-1 -: OCT_W];
    assign w_quot  = f_oct_quot(w_hi);
    assign w_remhi = HI_W'(int'(w_hi) - int'(w_quot) * K);
    assign w_frac  = r_prod2[SH2 +: FRAC_W];

    // Payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sum1 <= i_sum;
        end
        if (w_rdy2 && r_v1) begin
            r_prod1 <= {{M1_W{1'b0}}, r_sum1} * {{SUM_W{1'b0}}, M1};
        end
        if (w_rdy3 && r_v2) begin
            r_mean3 <= w_mean;
            r_oct3  <= w_quot + i_offset;
            r_rem3  <= {w_remhi, w_mean[7:0]};
        end
        if (w_rdy4 && r_v3) begin
            r_prod2 <= {{M2_W{1'b0}}, r_rem3} * {{REM_W{1'b0}}, M2};
            r_mean4 <= r_mean3;
            r_oct4  <= r_oct3;
        end
        if (w_rdy5 && r_v4) begin
            r_mean5 <= r_mean4;
            r_oct5  <= r_oct4;
            r_per5  <= {1'b1, w_frac};
            r_half5 <= {1'b1, w_frac[FRAC_W-1:1]};
        end
    end

    assign o_valid = r_v5;
    assign o_mean  = r_mean5;
    assign o_oct   = r_oct5;
    assign o_per   = r_per5;
    assign o_half  = r_half5;

endmodule

/* hw/rtl/edt_checker.sv */
module edt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata
);

    // Hold a stalled result
    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result dropped while stalled");

    a_stall_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))
        else $error("result changed while stalled");

    // Period in upper half range, half period its top bits, pad bit clear
    a_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[23] && (i_m_tdata[30:24] == i_m_tdata[23:17])
                       && !i_m_tdata[31])
        else $error("tone period fields inconsistent");

    // No result right out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result shown after reset");

endmodule

bind echo_distance_to_tone edt_checker u_edt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
